@@ hw/rtl/cdbd_pkg.sv @@
// Shared widths, types and calendar tables for the calendar day difference block.
`default_nettype none

package cdbd_pkg;

  // Field widths.
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DIFF_W  = 23;

  // The accumulator holds the unsaturated difference with headroom.
  localparam int ACC_W = 24;

  // A day-of-year base (month lengths before the month plus the day).
  localparam int DOY_W = 10;

  localparam int MAX_YEAR_DEFAULT = 9999;

  localparam int DAYS_YEAR = 365;
  localparam int CYC_100   = 100;
  localparam int CYC_400   = 400;
  localparam int C100_W    = 7;
  localparam int C400_W    = 9;

  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cdbd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic out_full;
  } cdbd_sts_t;

  // Days in the months before the given month of a common year.
  // Month zero counts as January and months above twelve as December.
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month);
    logic [8:0] days;
    unique case (month)
      4'd0, 4'd1: days = 9'd0;
      4'd2:       days = 9'd31;
      4'd3:       days = 9'd59;
      4'd4:       days = 9'd90;
      4'd5:       days = 9'd120;
      4'd6:       days = 9'd151;
      4'd7:       days = 9'd181;
      4'd8:       days = 9'd212;
      4'd9:       days = 9'd243;
      4'd10:      days = 9'd273;
      4'd11:      days = 9'd304;
      default:    days = 9'd334;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/calendar_days_between_dates_top.sv @@
// Top level of the calendar day difference block: controller plus datapath.
//
// Usage:
//   The input channel (in_valid / in_ready) carries one item of two dates,
//   each as day, month and year. The output channel (out_valid / out_ready)
//   carries the signed day count from the first date to the second; whole years
//   count only if the second year is not earlier. Years above MAX_YEAR are clamped to MAX_YEAR.
//   After an item is taken, the datapath sweeps one year per cycle from year
//   zero through the later of the two years, using the single year-sweep
//   counter; the finish state then loads the result register once it is
//   free, and the result is offered the cycle after that.
//   in_ready is high only in the idle state, so the next item can be
//   taken while the previous result still waits in the output register.
//   If the receiver stalls, a finished item waits in the sweep end state
//   until the output register is free; nothing is dropped.
//   Reset (rst, synchronous) returns the controller to idle and clears the
//   output valid flag.
`default_nettype none

module calendar_days_between_dates_top
  import cdbd_pkg::*;
#(
  parameter int MAX_YEAR = MAX_YEAR_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [DAY_W-1:0]     first_day,
  input  wire logic [MONTH_W-1:0]   first_month,
  input  wire logic [YEAR_W-1:0]    first_year,
  input  wire logic [DAY_W-1:0]     second_day,
  input  wire logic [MONTH_W-1:0]   second_month,
  input  wire logic [YEAR_W-1:0]    second_year,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [DIFF_W-1:0]  day_difference
);

  cdbd_cmd_t cmd;
  cdbd_sts_t sts;

  cdbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdbd_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .first_day      (first_day),
    .first_month    (first_month),
    .first_year     (first_year),
    .second_day     (second_day),
    .second_month   (second_month),
    .second_year    (second_year),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .day_difference (day_difference)
  );

endmodule

`default_nettype wire

@@ hw/rtl/cdbd_ctrl.sv @@
// Controller state machine that sequences the year sweep of one item.
`default_nettype none

module cdbd_ctrl
  import cdbd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      out_ready,
  input  wire cdbd_sts_t sts,
  output cdbd_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  state_t state;

  // A new item is taken only when no sweep is running.
  assign in_ready = (state == ST_IDLE);

  // Commands to the datapath.
  always_comb begin
    cmd.load   = in_valid && (state == ST_IDLE);
    cmd.step   = (state == ST_SWEEP);
    cmd.finish = (state == ST_FINISH) && (!sts.out_full || out_ready);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.load) state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (sts.last) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (cmd.finish) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The result register is only loaded when it is free or being emptied.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!sts.out_full || out_ready))
    else $error("result loaded over an item not yet taken");

  // The last swept year always leads to the finish step.
  a_last_to_finish: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && sts.last) |=> (state == ST_FINISH))
    else $error("sweep end did not reach finish");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/cdbd_dp.sv @@
// Datapath: date bases, year sweep with leap counters, accumulator and result register.
`default_nettype none

module cdbd_dp
  import cdbd_pkg::*;
#(
  parameter int MAX_YEAR = MAX_YEAR_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cdbd_cmd_t                 cmd,
  output cdbd_sts_t                      sts,
  input  wire logic [DAY_W-1:0]          first_day,
  input  wire logic [MONTH_W-1:0]        first_month,
  input  wire logic [YEAR_W-1:0]         first_year,
  input  wire logic [DAY_W-1:0]          second_day,
  input  wire logic [MONTH_W-1:0]        second_month,
  input  wire logic [YEAR_W-1:0]         second_year,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic signed [DIFF_W-1:0]       day_difference
);

  localparam int YW = $clog2(MAX_YEAR + 1);
  localparam int EW = (YW > YEAR_W) ? YW : YEAR_W;

  // The accumulator grows with the year range: up to 366 days per year plus sign.
  localparam int AW = (YW + 10 > ACC_W) ? YW + 10 : ACC_W;

  localparam logic signed [AW-1:0] OUT_MAX = AW'((1 << (DIFF_W - 1)) - 1);
  localparam logic signed [AW-1:0] OUT_MIN = -AW'(1 << (DIFF_W - 1));

  // Item registers.
  logic [YW-1:0]           y1;
  logic [YW-1:0]           y2;
  logic [YW-1:0]           ymax;
  logic                    mon1_gt2;
  logic                    mon2_gt2;
  logic signed [AW-1:0]    acc;

  // Sweep counters: year, and its remainders by 4, 100 and 400.
  logic [YW-1:0]     yc;
  logic [1:0]        m4;
  logic [C100_W-1:0] m100;
  logic [C400_W-1:0] m400;

  logic [YW-1:0]     y1_next;
  logic [YW-1:0]     y2_next;
  logic [DOY_W-1:0]  base1;
  logic [DOY_W-1:0]  base2;
  logic [EW-1:0]     fy_ext;
  logic [EW-1:0]     sy_ext;
  logic              leap;
  logic              in_span;
  logic [8:0]        year_days;
  logic              adj1;
  logic              adj2;
  logic signed [AW-1:0] acc_next;
  logic signed [DIFF_W-1:0] sat;

  // Clamp both years to the configured maximum.
  always_comb begin
    fy_ext = EW'(first_year);
    sy_ext = EW'(second_year);
    if (fy_ext > EW'(MAX_YEAR)) y1_next = YW'(MAX_YEAR);
    else                        y1_next = fy_ext[YW-1:0];
    if (sy_ext > EW'(MAX_YEAR)) y2_next = YW'(MAX_YEAR);
    else                        y2_next = sy_ext[YW-1:0];
  end

  // Day of year without the leap day; that day is added during the sweep.
  assign base1 = DOY_W'(days_before_month(first_month)) + DOY_W'(first_day);
  assign base2 = DOY_W'(days_before_month(second_month)) + DOY_W'(second_day);

  // Leap test of the swept year from its remainder counters.
  assign leap = ((m4 == 2'd0) && (m100 != '0)) || (m400 == '0);

  // Contribution of the swept year to the accumulator.
  always_comb begin
    in_span   = (yc >= y1) && (yc < y2);
    year_days = in_span ? (9'(DAYS_YEAR) + 9'(leap)) : 9'd0;
    adj2      = (yc == y2) && mon2_gt2 && leap;
    adj1      = (yc == y1) && mon1_gt2 && leap;
    acc_next  = acc + AW'(year_days) + AW'(adj2) - AW'(adj1);
  end

  // Saturate to the result width.
  always_comb begin
    if (acc > OUT_MAX)      sat = OUT_MAX[DIFF_W-1:0];
    else if (acc < OUT_MIN) sat = OUT_MIN[DIFF_W-1:0];
    else                    sat = acc[DIFF_W-1:0];
  end

  assign sts.last     = (yc == ymax);
  assign sts.out_full = out_valid;

  // Item load and year sweep.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y1       <= y1_next;
      y2       <= y2_next;
      ymax     <= (y1_next > y2_next) ? y1_next : y2_next;
      mon1_gt2 <= first_month > MONTH_FEB;
      mon2_gt2 <= second_month > MONTH_FEB;
      acc      <= AW'(base2) - AW'(base1);
      yc       <= '0;
      m4       <= '0;
      m100     <= '0;
      m400     <= '0;
    end else if (cmd.step) begin
      acc  <= acc_next;
      yc   <= yc + YW'(1);
      m4   <= m4 + 2'd1;
      m100 <= (m100 == C100_W'(CYC_100 - 1)) ? '0 : m100 + C100_W'(1);
      m400 <= (m400 == C400_W'(CYC_400 - 1)) ? '0 : m400 + C400_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) day_difference <= sat;
  end

`ifndef ASSERT_OFF
  // The sweep never runs past the later year.
  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (yc <= ymax))
    else $error("year sweep passed its end");

  // A finished item is offered in the next cycle.
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished item not offered");
`endif

endmodule

`default_nettype wire
